// ===== src/sat_pkg.sv =====
// Shared constants, types and address helper for the summed-area table engine.
package sat_pkg;

  // Largest table the memory holds
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int TBL_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  // Field widths
  localparam int DIM_W = 7;
  localparam int ELEM_W = 32;
  localparam int SUM_W = 48;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_RECT   = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  // Accumulator operation for the inclusion-exclusion sequence
  typedef enum logic [1:0] {
    ACC_NONE   = 2'd0,
    ACC_LOAD   = 2'd1,
    ACC_SUB    = 2'd2,
    ACC_FINISH = 2'd3
  } acc_op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              rs_add;      // add the incoming element to the row sum
    logic              rs_restart;  // row sum starts from zero for this add
    logic              rs_clear;    // zero the row sum
    logic              wr_en;       // write a table entry
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              term_zero;   // read data of last cycle counts as zero
    acc_op_t           acc_op;
    logic              emit_err;    // send an error result
    status_t           err_status;
  } sat_cmd_t;

  // Linear address of the 1-based entry (row1, col1)
  function automatic logic [ADDR_W-1:0] sat_addr(input logic [DIM_W-1:0] row1,
                                                 input logic [DIM_W-1:0] col1);
    logic [DIM_W-1:0] r0;
    logic [DIM_W-1:0] c0;
    int               lin;
    r0  = row1 - DIM_W'(1);
    c0  = col1 - DIM_W'(1);
    lin = int'(r0) * MAX_COLS + int'(c0);
    return ADDR_W'(lin);
  endfunction

  // Clamp a written dimension into 1..max
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      res = DIM_W'(maxv);
    end
    return res;
  endfunction

endpackage

// ===== src/sat_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sat_dp.sv =====
// Datapath: table memory, row running sum, query accumulator and result register.
module sat_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [sat_pkg::ELEM_W-1:0] in_element,
  input  sat_pkg::sat_cmd_t      cmd,
  output logic [sat_pkg::SUM_W-1:0]  out_rect_sum,
  output logic [sat_pkg::STAT_W-1:0] out_status,
  output logic                   out_strobe
);
  import sat_pkg::*;

  logic [SUM_W-1:0]  rs_r, rs_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              strobe_r, strobe_nxt;
  logic [SUM_W-1:0]  rdata;
  logic [SUM_W-1:0]  term;
  logic [SUM_W-1:0]  elem_ext;
  logic [SUM_W-1:0]  wdata;

  sat_ram #(
    .WIDTH(SUM_W),
    .DEPTH(TBL_DEPTH)
  ) u_tbl (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(cmd.wr_addr),
    .wdata(wdata),
    .raddr(cmd.rd_addr),
    .rdata(rdata)
  );

  assign elem_ext = {{(SUM_W - ELEM_W){in_element[ELEM_W-1]}}, in_element};
  assign term     = cmd.term_zero ? '0 : rdata;
  assign wdata    = rs_r + term;

  // Advance the row sum
  always_comb begin
    rs_nxt = rs_r;
    if (cmd.rs_clear) begin
      rs_nxt = '0;
    end else if (cmd.rs_add) begin
      rs_nxt = (cmd.rs_restart ? '0 : rs_r) + elem_ext;
    end
  end

  // Accumulate the four corner terms and load the result
  always_comb begin
    acc_nxt    = acc_r;
    sum_nxt    = sum_r;
    stat_nxt   = stat_r;
    strobe_nxt = 1'b0;
    unique case (cmd.acc_op)
      ACC_NONE:   acc_nxt = acc_r;
      ACC_LOAD:   acc_nxt = term;
      ACC_SUB:    acc_nxt = acc_r - term;
      ACC_FINISH: begin
        sum_nxt    = acc_r + term;
        stat_nxt   = ST_OK;
        strobe_nxt = 1'b1;
      end
      default:    acc_nxt = acc_r;
    endcase
    if (cmd.emit_err) begin
      sum_nxt    = '0;
      stat_nxt   = cmd.err_status;
      strobe_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      rs_r     <= rs_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    stat_r <= stat_nxt;
  end

  assign out_rect_sum = sum_r;
  assign out_status   = stat_r;
  assign out_strobe   = strobe_r;

endmodule

// ===== src/sat_ctrl.sv =====
// Controller: state machine, load counters, configuration and query corners.
module sat_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [sat_pkg::DIM_W-1:0]   in_top_row,
  input  logic [sat_pkg::DIM_W-1:0]   in_left_col,
  input  logic [sat_pkg::DIM_W-1:0]   in_bottom_row,
  input  logic [sat_pkg::DIM_W-1:0]   in_right_col,
  input  logic                        cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sat_pkg::DIM_W-1:0]   cfg_wdata,
  output sat_pkg::sat_cmd_t           cmd
);
  import sat_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LDWR = 6'b000010,
    S_QB   = 6'b000100,
    S_QC   = 6'b001000,
    S_QD   = 6'b010000,
    S_QE   = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [DIM_W-1:0] rows_r, rows_nxt;
  logic [DIM_W-1:0] cols_r, cols_nxt;
  logic [DIM_W-1:0] load_row_r, load_row_nxt;
  logic [DIM_W-1:0] load_col_r, load_col_nxt;
  logic             complete_r, complete_nxt;
  logic             tz_r, tz_nxt;
  logic [DIM_W-1:0] top_r, left_r, bot_r, right_r;
  logic             accept;
  logic             bad_rect;
  logic [DIM_W-1:0] row_eff, col_eff;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic [DIM_W-1:0] top_m1, left_m1;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign row_eff = complete_r ? '0 : load_row_r;
  assign col_eff = complete_r ? '0 : load_col_r;
  assign col_inc = load_col_r + DIM_W'(1);
  assign row_inc = load_row_r + DIM_W'(1);
  assign top_m1  = top_r - DIM_W'(1);
  assign left_m1 = left_r - DIM_W'(1);

  assign bad_rect = (in_top_row == '0) || (in_left_col == '0) ||
                    (in_top_row > in_bottom_row) || (in_left_col > in_right_col) ||
                    (in_bottom_row > rows_r) || (in_right_col > cols_r);

  // Sequence loads and queries
  always_comb begin
    state_nxt    = state_r;
    rows_nxt     = rows_r;
    cols_nxt     = cols_r;
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    complete_nxt = complete_r;
    tz_nxt       = tz_r;

    cmd            = '0;
    cmd.acc_op     = ACC_NONE;
    cmd.err_status = ST_OK;
    cmd.term_zero  = tz_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_action) begin
            // Load: add element, fetch the entry above
            cmd.rs_add     = 1'b1;
            cmd.rs_restart = complete_r;
            cmd.rd_addr    = sat_addr(row_eff, col_eff + DIM_W'(1));
            tz_nxt         = (row_eff == '0);
            load_row_nxt   = row_eff;
            load_col_nxt   = col_eff;
            complete_nxt   = 1'b0;
            state_nxt      = S_LDWR;
          end else if (!complete_r) begin
            cmd.emit_err   = 1'b1;
            cmd.err_status = ST_INCOMPLETE;
          end else if (bad_rect) begin
            cmd.emit_err   = 1'b1;
            cmd.err_status = ST_BAD_RECT;
          end else begin
            // Query: fetch the bottom-right corner first
            cmd.rd_addr = sat_addr(in_bottom_row, in_right_col);
            tz_nxt      = 1'b0;
            state_nxt   = S_QB;
          end
        end
      end
      S_LDWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = sat_addr(row_inc, col_inc);
        if (col_inc >= cols_r) begin
          load_col_nxt = '0;
          cmd.rs_clear = 1'b1;
          if (row_inc >= rows_r) begin
            load_row_nxt = '0;
            complete_nxt = 1'b1;
          end else begin
            load_row_nxt = row_inc;
          end
        end else begin
          load_col_nxt = col_inc;
        end
        state_nxt = S_IDLE;
      end
      S_QB: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.rd_addr = sat_addr(top_m1, right_r);
        tz_nxt      = (top_m1 == '0);
        state_nxt   = S_QC;
      end
      S_QC: begin
        cmd.acc_op  = ACC_SUB;
        cmd.rd_addr = sat_addr(bot_r, left_m1);
        tz_nxt      = (left_m1 == '0);
        state_nxt   = S_QD;
      end
      S_QD: begin
        cmd.acc_op  = ACC_SUB;
        cmd.rd_addr = sat_addr(top_m1, left_m1);
        tz_nxt      = (top_m1 == '0) || (left_m1 == '0);
        state_nxt   = S_QE;
      end
      S_QE: begin
        cmd.acc_op = ACC_FINISH;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // Configuration write restarts loading
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROWS: rows_nxt = clamp_dim(cfg_wdata, MAX_ROWS);
        REG_COLS: cols_nxt = clamp_dim(cfg_wdata, MAX_COLS);
        default:  rows_nxt = rows_r;
      endcase
      load_row_nxt = '0;
      load_col_nxt = '0;
      complete_nxt = 1'b0;
      cmd.rs_clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rows_r     <= clamp_dim(DIM_W'(64), MAX_ROWS);
      cols_r     <= clamp_dim(DIM_W'(64), MAX_COLS);
      load_row_r <= '0;
      load_col_r <= '0;
      complete_r <= 1'b0;
      tz_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rows_r     <= rows_nxt;
      cols_r     <= cols_nxt;
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      complete_r <= complete_nxt;
      tz_r       <= tz_nxt;
    end
  end

  // Hold the query corners
  always_ff @(posedge clk) begin
    if (accept) begin
      top_r   <= in_top_row;
      left_r  <= in_left_col;
      bot_r   <= in_bottom_row;
      right_r <= in_right_col;
    end
  end

endmodule

// ===== src/summed_area_table_engine.sv =====
// Top level of the summed-area table engine: controller plus datapath.
//
//  Channel   Ports                                        Transfer
//  input     in_action, in_element, in_top_row,           start high, busy low
//            in_left_col, in_bottom_row, in_right_col
//  result    out_rect_sum, out_status                     out_strobe high, one cycle
//  config    cfg_index, cfg_wdata                         cfg_we high
//
// A load reads the entry above, then writes the new entry.
// A valid query makes four reads through the single table read port, with the
// result strobe in the cycle after the last read returns. A query that fails its
// checks gives its result in the cycle after the transfer and keeps busy low.
// Reset (synchronous, rst_n low) sets a 64 x 64 table with no rows loaded; the
// table memory is not cleared. The receiver cannot stall results.
module summed_area_table_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [sat_pkg::ELEM_W-1:0]    in_element,
  input  logic [sat_pkg::DIM_W-1:0]     in_top_row,
  input  logic [sat_pkg::DIM_W-1:0]     in_left_col,
  input  logic [sat_pkg::DIM_W-1:0]     in_bottom_row,
  input  logic [sat_pkg::DIM_W-1:0]     in_right_col,
  output logic                          out_strobe,
  output logic [sat_pkg::SUM_W-1:0]     out_rect_sum,
  output logic [sat_pkg::STAT_W-1:0]    out_status,
  input  logic                          cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sat_pkg::DIM_W-1:0]     cfg_wdata
);
  import sat_pkg::*;

  sat_cmd_t cmd;

  sat_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_top_row   (in_top_row),
    .in_left_col  (in_left_col),
    .in_bottom_row(in_bottom_row),
    .in_right_col (in_right_col),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd)
  );

  sat_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_element  (in_element),
    .cmd         (cmd),
    .out_rect_sum(out_rect_sum),
    .out_status  (out_status),
    .out_strobe  (out_strobe)
  );

endmodule
